@@ rtl/over_temperature_monitor_core_defines.svh @@
// Assertion macros used by the checker file of the over-temperature monitor.
`ifndef OVER_TEMPERATURE_MONITOR_CORE_DEFINES_SVH
`define OVER_TEMPERATURE_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet while in reset
`define OTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, quiet while in reset
`define OTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/otm_pkg.sv @@
`default_nettype none

package otm_pkg;

    // Field widths
    localparam int SAMPLE_BITS    = 10;
    localparam int TICK_BITS      = 16;
    localparam int COUNT_BITS     = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [TICK_BITS-1:0]   t_tick;
    typedef logic [COUNT_BITS-1:0]  t_count;

    // Register reset values
    localparam t_sample RELEASE_LEVEL_RESET = {SAMPLE_BITS{1'b1}};
    localparam t_count  CONFIRM_RESET       = 8'd3;
    localparam t_tick   IDLE_TICKS_RESET    = 16'd1000;
    localparam t_count  WINDOW_TICKS_RESET  = 8'd7;

    localparam t_tick  TICK_MAX  = {TICK_BITS{1'b1}};
    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE        = 3'd0,
        CFG_DANGER_LEVEL  = 3'd1,
        CFG_RELEASE_LEVEL = 3'd2,
        CFG_CONFIRM_COUNT = 3'd3,
        CFG_IDLE_TICKS    = 3'd4,
        CFG_WINDOW_TICKS  = 3'd5
    } t_cfg_index;

    // Input item: tick (cmd 0) or converter sample (cmd 1)
    typedef struct packed {
        logic    cmd;
        logic    load_ok;
        logic    power_ok;
        t_sample sample;
    } t_in_item;

    typedef struct packed {
        logic    error_flag;
        logic    safe_flag;
        logic    sampling;
        t_sample reading;
        logic    reading_done;
        logic    error_raised;
        logic    error_cleared;
    } t_out_item;

    typedef struct packed {
        logic    enable;
        t_sample danger_level;
        t_sample release_level;
        t_count  confirm_count;
        t_tick   idle_ticks;
        t_count  window_ticks;
    } t_cfg;

    typedef struct packed {
        logic    window_open;
        t_tick   tick_count;
        t_sample peak_first;
        t_sample peak_second;
        t_count  qualify_count;
        logic    error_state;
        logic    safe_state;
        t_sample last_reading;
    } t_state;

endpackage

`default_nettype wire

@@ rtl/otm_cfg_regs.sv @@
`default_nettype none

module otm_cfg_regs
    import otm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output t_cfg                           o_cfg
);

    t_cfg r_cfg;

    // Register file; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.danger_level  <= '0;
            r_cfg.release_level <= RELEASE_LEVEL_RESET;
            r_cfg.confirm_count <= CONFIRM_RESET;
            r_cfg.idle_ticks    <= IDLE_TICKS_RESET;
            r_cfg.window_ticks  <= WINDOW_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:        r_cfg.enable        <= i_cfg_wdata[0];
                CFG_DANGER_LEVEL:  r_cfg.danger_level  <= i_cfg_wdata[SAMPLE_BITS-1:0];
                CFG_RELEASE_LEVEL: r_cfg.release_level <= i_cfg_wdata[SAMPLE_BITS-1:0];
                CFG_CONFIRM_COUNT: r_cfg.confirm_count <= i_cfg_wdata[COUNT_BITS-1:0];
                CFG_IDLE_TICKS:    r_cfg.idle_ticks    <= i_cfg_wdata[TICK_BITS-1:0];
                CFG_WINDOW_TICKS:  r_cfg.window_ticks  <= i_cfg_wdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/otm_step.sv @@
`default_nettype none

module otm_step
    import otm_pkg::*;
(
    input  wire t_cfg      i_cfg,
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    output t_state    o_state_next,
    output t_out_item o_result
);

    t_state ns;
    t_tick  tick_inc;
    t_count qual_inc;
    logic   done;
    logic   raised;
    logic   cleared;

    // Saturating increments of the two counters
    assign tick_inc = (i_state.tick_count == TICK_MAX) ? i_state.tick_count
                                                       : i_state.tick_count + 16'd1;
    assign qual_inc = (i_state.qualify_count == COUNT_MAX) ? i_state.qualify_count
                                                           : i_state.qualify_count + 8'd1;

    // State update for one item
    always_comb begin
        ns      = i_state;
        done    = 1'b0;
        raised  = 1'b0;
        cleared = 1'b0;
        if (i_item.cmd) begin
            // Peak cascade, only while the window is open
            if (i_state.window_open) begin
                if (i_state.peak_first < i_item.sample) begin
                    ns.peak_first = i_item.sample;
                end else if (i_state.peak_second < i_item.sample) begin
                    ns.peak_second = i_item.sample;
                end
            end
        end else if (i_cfg.enable) begin
            ns.tick_count = tick_inc;
            if (!i_state.window_open) begin
                // End of idle period: open only when load and supply are safe
                if (tick_inc >= i_cfg.idle_ticks) begin
                    if (i_item.load_ok && i_item.power_ok) begin
                        ns.tick_count  = '0;
                        ns.window_open = 1'b1;
                        ns.safe_state  = 1'b0;
                    end else begin
                        ns.tick_count = i_cfg.idle_ticks;
                    end
                end
            end else if (tick_inc >= {{(TICK_BITS-COUNT_BITS){1'b0}}, i_cfg.window_ticks}) begin
                // Window closes: publish second peak, run hysteresis
                ns.tick_count   = '0;
                ns.window_open  = 1'b0;
                ns.last_reading = i_state.peak_second;
                done            = 1'b1;
                if (i_state.error_state) begin
                    if (i_state.peak_second >= i_cfg.release_level) begin
                        ns.qualify_count = qual_inc;
                        if (qual_inc >= i_cfg.confirm_count) begin
                            ns.qualify_count = '0;
                            ns.error_state   = 1'b0;
                            ns.safe_state    = 1'b1;
                            cleared          = 1'b1;
                        end
                    end else begin
                        ns.qualify_count = '0;
                    end
                end else begin
                    if (i_state.peak_second <= i_cfg.danger_level) begin
                        ns.qualify_count = qual_inc;
                        if (qual_inc >= i_cfg.confirm_count) begin
                            ns.qualify_count = '0;
                            ns.error_state   = 1'b1;
                            raised           = 1'b1;
                        end
                    end else begin
                        ns.qualify_count = '0;
                    end
                end
                if (!ns.error_state) begin
                    ns.safe_state = 1'b1;
                end
                ns.peak_first  = '0;
                ns.peak_second = '0;
            end
        end
    end

    assign o_state_next = ns;

    // Result item reports the state after the update
    always_comb begin
        o_result.error_flag    = ns.error_state;
        o_result.safe_flag     = ns.safe_state;
        o_result.sampling      = ns.window_open;
        o_result.reading       = ns.last_reading;
        o_result.reading_done  = done;
        o_result.error_raised  = raised;
        o_result.error_cleared = cleared;
    end

endmodule

`default_nettype wire

@@ rtl/over_temperature_monitor_core.sv @@
// An accepted input item is held in the input register, then passes through the update
// logic into the result register. Throughput: one item per cycle while the output is
// not stalled; the input register refills in the same cycle it drains.
// Reset (i_rst_n low, synchronous): both stages empty, config registers and
// monitor state at their reset values (safe flag set, error clear).
`default_nettype none

module over_temperature_monitor_core
    import otm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire t_in_item                  i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output t_out_item                      o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out;
    logic      advance;

    otm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    otm_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_item       (r_in),
        .o_state_next (n_state),
        .o_result     (n_out)
    );

    // Held item moves into the result register when that slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Monitor state commits as the item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window_open   <= 1'b0;
            r_state.tick_count    <= '0;
            r_state.peak_first    <= '0;
            r_state.peak_second   <= '0;
            r_state.qualify_count <= '0;
            r_state.error_state   <= 1'b0;
            r_state.safe_state    <= 1'b1;
            r_state.last_reading  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/otm_checker.sv @@
`default_nettype none
`include "over_temperature_monitor_core_defines.svh"

module otm_checker
    import otm_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_out_item  o_out_data
);

    // A stalled result item holds
    `OTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // An error is only raised or cleared when a window closes
    `OTM_ASSERT_NOW(a_pulse_on_close, i_clk, i_rst_n, o_out_valid && (o_out_data.error_raised || o_out_data.error_cleared), o_out_data.reading_done && !o_out_data.sampling)

    // An active error always means the safe flag is down
    `OTM_ASSERT_NOW(a_error_not_safe, i_clk, i_rst_n, o_out_valid && o_out_data.error_flag, !o_out_data.safe_flag)

    // The cleared pulse agrees with the flags it reports
    `OTM_ASSERT_NOW(a_pulse_flag, i_clk, i_rst_n, o_out_valid && o_out_data.error_cleared, !o_out_data.error_flag && o_out_data.safe_flag && !o_out_data.error_raised)

endmodule

bind over_temperature_monitor_core otm_checker u_otm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
